>>> src/fbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types, codes and constants of the frame byte deobfuscator.
// ----------------------------------------------------------------------------
package fbd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 64 << 10;

  localparam int NUM_W = 8;
  localparam int DEN_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_TWIRL_DIVISOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LENGTHS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_CHECKSUM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL = 2'd3;

  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_LEN_ERROR = 2'd2;

  localparam logic [7:0] KEY_STEP = 8'd33;
  localparam logic [7:0] KEY_BIAS = 8'd2;
  localparam logic [1:0] LAST_IDX_SHORT = 2'd1;
  localparam logic [1:0] LAST_IDX_LONG = 2'd3;

  typedef enum logic [3:0] {
    PH_LENGTH   = 4'b0001,
    PH_STAMP    = 4'b0010,
    PH_PAYLOAD  = 4'b0100,
    PH_CHECKSUM = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    CT_IDLE = 3'b001,
    CT_CALC = 3'b010,
    CT_EMIT = 3'b100
  } ctl_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [DEN_W-1:0] rem;
  } mod_rsp_t;

endpackage

>>> src/fbd_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbd_mod_unit
// Restoring remainder unit: one numerator bit per cycle, 8-bit by 4-bit.
// ----------------------------------------------------------------------------
module fbd_mod_unit (
  input  logic              clk,
  input  logic              rst,
  input  fbd_pkg::mod_req_t req,
  output fbd_pkg::mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(fbd_pkg::NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(fbd_pkg::NUM_W - 1);

  logic                       busy;
  logic                       done;
  logic [CNT_W-1:0]           cnt;
  logic [fbd_pkg::NUM_W-1:0]  num_sh;
  logic [fbd_pkg::DEN_W-1:0]  den_q;
  logic [fbd_pkg::DEN_W-1:0]  rem;
  logic [fbd_pkg::DEN_W:0]    trial;
  logic [fbd_pkg::DEN_W:0]    diff;
  logic                       fits;

  assign trial = {rem, num_sh[fbd_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= req.num;
      den_q  <= req.den;
      rem    <= '0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      rem    <= fits ? diff[fbd_pkg::DEN_W-1:0] : trial[fbd_pkg::DEN_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

>>> src/frame_byte_deobfuscator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_byte_deobfuscator_core
// Frame parser and payload byte deobfuscator over a recording body stream.
// ----------------------------------------------------------------------------
// Header, timestamp and checksum bytes are taken in the idle state; a length
// error or an empty-frame marker goes to the emit state, which loads the output
// register once it is free. Payload bytes with a zero or power-of-two divisor
// go straight to emit; others wait in calc for the 8-step remainder unit.
// A result may wait in the output register while the next request enters.
// Synchronous reset returns the parser to the length field and clears errors.
// ----------------------------------------------------------------------------
module frame_byte_deobfuscator_core #(
  parameter int MAX_FRAME_BYTES = fbd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       body_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       plain_byte,
  output logic [31:0]                      frame_time,
  output logic                             frame_end,
  output logic                             recording_end,
  output logic [1:0]                       status
);

  localparam int BL_W = $clog2(MAX_FRAME_BYTES + 1);

  fbd_pkg::ctl_t    ctl;
  fbd_pkg::phase_t  phase;

  logic [3:0]       twirl_divisor;
  logic             short_lengths;
  logic             has_checksum;
  logic [30:0]      frame_total;

  logic [1:0]       field_idx;
  logic [31:0]      frame_length;
  logic [31:0]      frame_stamp;
  logic [BL_W-1:0]  bytes_left;
  logic [7:0]       key_byte;
  logic [30:0]      frames_done;
  logic             error_seen;

  logic [7:0]       pend_plain;
  logic [7:0]       pend_in;
  logic [7:0]       pend_key;
  logic [3:0]       pend_div;
  logic [31:0]      pend_time;
  logic             pend_fe;
  logic             pend_re;
  logic [1:0]       pend_status;

  logic             accept;
  logic             out_free;
  logic [31:0]      len_acc;
  logic [31:0]      stamp_acc;
  logic             body_done;
  logic [1:0]       last_idx;
  logic             last_frame;
  logic             div_pow2;
  logic             needs_mod;
  logic [7:0]       mod_num;
  logic             pay_fe;

  fbd_pkg::mod_req_t mod_req;
  fbd_pkg::mod_rsp_t mod_rsp;

  function automatic logic [7:0] untwirl(input logic [7:0] in_b, input logic [7:0] a,
                                         input logic [3:0] d, input logic [3:0] b);
    logic [3:0] corr;
    corr = (b != 4'd0) ? (d - b) : 4'd0;
    return in_b - a - {4'd0, corr};
  endfunction

  assign accept     = in_valid && !in_stall;
  assign in_stall   = ctl != fbd_pkg::CT_IDLE;
  assign out_free   = !out_valid || !out_stall;
  assign len_acc    = ((field_idx == 2'd0) ? 32'd0 : frame_length)
                      | ({24'd0, body_byte} << {field_idx, 3'b000});
  assign stamp_acc  = ((field_idx == 2'd0) ? 32'd0 : frame_stamp)
                      | ({24'd0, body_byte} << {field_idx, 3'b000});
  assign body_done  = frames_done >= frame_total;
  assign last_idx   = short_lengths ? fbd_pkg::LAST_IDX_SHORT : fbd_pkg::LAST_IDX_LONG;
  assign last_frame = (frames_done + 31'd1) == frame_total;
  assign div_pow2   = (twirl_divisor & (twirl_divisor - 4'd1)) == 4'd0;
  assign needs_mod  = (twirl_divisor != 4'd0) && !div_pow2;
  assign mod_num    = key_byte - {7'd0, key_byte[7]};
  assign pay_fe     = bytes_left == BL_W'(1);

  assign mod_req.start = accept && !error_seen && (phase == fbd_pkg::PH_PAYLOAD) && needs_mod;
  assign mod_req.num   = mod_num;
  assign mod_req.den   = twirl_divisor;

  fbd_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      twirl_divisor <= '0;
      short_lengths <= 1'b0;
      has_checksum  <= 1'b0;
      frame_total   <= 31'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fbd_pkg::REG_TWIRL_DIVISOR: twirl_divisor <= cfg_data[3:0];
        fbd_pkg::REG_SHORT_LENGTHS: short_lengths <= cfg_data[0];
        fbd_pkg::REG_HAS_CHECKSUM:  has_checksum  <= cfg_data[0];
        fbd_pkg::REG_FRAME_TOTAL:   frame_total   <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame parser and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl          <= fbd_pkg::CT_IDLE;
      phase        <= fbd_pkg::PH_LENGTH;
      field_idx    <= '0;
      frame_length <= '0;
      frame_stamp  <= '0;
      bytes_left   <= '0;
      key_byte     <= '0;
      frames_done  <= '0;
      error_seen   <= 1'b0;
    end else begin
      unique case (ctl)
        fbd_pkg::CT_IDLE: begin
          if (accept && !error_seen) begin
            unique case (phase)
              fbd_pkg::PH_LENGTH: begin
                if (!body_done) begin
                  frame_length <= len_acc;
                  if (field_idx >= last_idx) begin
                    field_idx <= '0;
                    if (len_acc > 32'(MAX_FRAME_BYTES)) begin
                      error_seen <= 1'b1;
                      ctl        <= fbd_pkg::CT_EMIT;
                    end else begin
                      phase <= fbd_pkg::PH_STAMP;
                    end
                  end else begin
                    field_idx <= field_idx + 2'd1;
                  end
                end
              end
              fbd_pkg::PH_STAMP: begin
                frame_stamp <= stamp_acc;
                if (field_idx != 2'd3) begin
                  field_idx <= field_idx + 2'd1;
                end else begin
                  field_idx  <= '0;
                  key_byte   <= frame_length[7:0] + stamp_acc[7:0] + fbd_pkg::KEY_BIAS;
                  bytes_left <= frame_length[BL_W-1:0];
                  if (frame_length == 32'd0) begin
                    ctl <= fbd_pkg::CT_EMIT;
                    if (has_checksum) begin
                      phase <= fbd_pkg::PH_CHECKSUM;
                    end else begin
                      phase       <= fbd_pkg::PH_LENGTH;
                      frames_done <= frames_done + 31'd1;
                    end
                  end else begin
                    phase <= fbd_pkg::PH_PAYLOAD;
                  end
                end
              end
              fbd_pkg::PH_PAYLOAD: begin
                key_byte   <= key_byte + fbd_pkg::KEY_STEP;
                bytes_left <= bytes_left - BL_W'(1);
                ctl        <= needs_mod ? fbd_pkg::CT_CALC : fbd_pkg::CT_EMIT;
                if (pay_fe) begin
                  field_idx <= '0;
                  if (has_checksum) begin
                    phase <= fbd_pkg::PH_CHECKSUM;
                  end else begin
                    phase       <= fbd_pkg::PH_LENGTH;
                    frames_done <= frames_done + 31'd1;
                  end
                end
              end
              fbd_pkg::PH_CHECKSUM: begin
                if (field_idx != 2'd3) begin
                  field_idx <= field_idx + 2'd1;
                end else begin
                  field_idx   <= '0;
                  phase       <= fbd_pkg::PH_LENGTH;
                  frames_done <= frames_done + 31'd1;
                end
              end
              default: ;
            endcase
          end
        end
        fbd_pkg::CT_CALC: begin
          if (mod_rsp.done) begin
            ctl <= fbd_pkg::CT_EMIT;
          end
        end
        fbd_pkg::CT_EMIT: begin
          if (out_free) begin
            ctl <= fbd_pkg::CT_IDLE;
          end
        end
        default: ctl <= fbd_pkg::CT_IDLE;
      endcase
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (ctl == fbd_pkg::CT_IDLE && accept && !error_seen) begin
      pend_in  <= body_byte;
      pend_key <= key_byte;
      pend_div <= twirl_divisor;
      unique case (phase)
        fbd_pkg::PH_LENGTH: begin
          pend_plain  <= 8'd0;
          pend_time   <= 32'd0;
          pend_fe     <= 1'b0;
          pend_re     <= 1'b0;
          pend_status <= fbd_pkg::ST_LEN_ERROR;
        end
        fbd_pkg::PH_PAYLOAD: begin
          if (twirl_divisor == 4'd0) begin
            pend_plain <= body_byte;
          end else begin
            pend_plain <= untwirl(body_byte, key_byte, twirl_divisor,
                                  key_byte[3:0] & (twirl_divisor - 4'd1));
          end
          pend_time   <= frame_stamp;
          pend_fe     <= pay_fe;
          pend_re     <= pay_fe && last_frame;
          pend_status <= fbd_pkg::ST_PAYLOAD;
        end
        default: begin
          pend_plain  <= 8'd0;
          pend_time   <= stamp_acc;
          pend_fe     <= 1'b1;
          pend_re     <= last_frame;
          pend_status <= fbd_pkg::ST_EMPTY;
        end
      endcase
    end else if (ctl == fbd_pkg::CT_CALC && mod_rsp.done) begin
      pend_plain <= untwirl(pend_in, pend_key, pend_div, mod_rsp.rem);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl == fbd_pkg::CT_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl == fbd_pkg::CT_EMIT && out_free) begin
      plain_byte    <= pend_plain;
      frame_time    <= pend_time;
      frame_end     <= pend_fe;
      recording_end <= pend_re;
      status        <= pend_status;
    end
  end

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> ctl == fbd_pkg::CT_CALC)
    else $error("remainder done outside calc");

  a_error_emits: assert property (@(posedge clk) disable iff (rst)
    $rose(error_seen) |-> ctl == fbd_pkg::CT_EMIT)
    else $error("length error without result");

  a_no_calc_after_error: assert property (@(posedge clk) disable iff (rst)
    error_seen && $past(error_seen) |-> ctl != fbd_pkg::CT_CALC)
    else $error("work after length error");

  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    phase == fbd_pkg::PH_PAYLOAD |-> bytes_left != '0)
    else $error("payload phase with no bytes left");

  a_error_result_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == fbd_pkg::ST_LEN_ERROR |-> !frame_end && !recording_end)
    else $error("error result marked as frame end");

endmodule

>>> tb/sv/frame_byte_deobfuscator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_byte_deobfuscator_checker
// Watches the configuration port and both byte channels of the deobfuscator.
// It keeps its own frame parser and key state, queues the result, if any, that
// each accepted body byte should cause, and compares every accepted result with
// the oldest queued one. It reports the open results and the failures.
// ----------------------------------------------------------------------------
module frame_byte_deobfuscator_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [fbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     body_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     plain_byte,
  input  logic [31:0]                    frame_time,
  input  logic                           frame_end,
  input  logic                           recording_end,
  input  logic [1:0]                     status,
  output int                             pending,
  output int                             failures
);

  typedef struct packed {
    logic [7:0]  plain;
    logic [31:0] stamp;
    logic        fend;
    logic        rend;
    logic [1:0]  st;
  } deob_result_t;

  deob_result_t awaited[$];
  deob_result_t head;
  deob_result_t seen;
  int           fail_count = 0;

  logic [3:0]  divisor;
  logic        short_len;
  logic        chk_on;
  logic [30:0] frame_total;

  fbd_pkg::phase_t parse;
  logic [1:0]  field_idx;
  logic [31:0] len_acc;
  logic [31:0] stamp_acc;
  logic [16:0] left;
  logic [7:0]  key;
  logic [30:0] frames_done;
  logic        halted;

  assign failures = fail_count;

  function automatic logic [7:0] strip_key(input logic [7:0] raw, input logic [7:0] k);
    logic [7:0] d8;
    logic [7:0] rem;
    logic [7:0] corr;
    d8 = {4'd0, divisor};
    if (divisor == 4'd0) return raw;
    if ((divisor & (divisor - 4'd1)) == 4'd0) rem = k & (d8 - 8'd1);
    else rem = (k - {7'd0, k[7]}) % d8;
    corr = (rem != 8'd0) ? d8 - rem : 8'd0;
    return raw - k - corr;
  endfunction

  function automatic logic is_final();
    return ({1'b0, frames_done} + 32'd1) == {1'b0, frame_total};
  endfunction

  task automatic queue_result(input logic [7:0] p, input logic [31:0] t, input logic fe,
                              input logic re, input logic [1:0] s);
    deob_result_t r;
    r.plain = p;
    r.stamp = t;
    r.fend = fe;
    r.rend = re;
    r.st = s;
    awaited.push_back(r);
  endtask

  task automatic end_payload();
    field_idx = 2'd0;
    if (chk_on) begin
      parse = fbd_pkg::PH_CHECKSUM;
    end else begin
      parse = fbd_pkg::PH_LENGTH;
      frames_done = frames_done + 31'd1;
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic fe;
    if (halted) return;
    case (parse)
      fbd_pkg::PH_LENGTH: begin
        if ({1'b0, frames_done} >= {1'b0, frame_total}) return;
        if (field_idx == 2'd0) len_acc = 32'd0;
        len_acc = len_acc | ({24'd0, b} << (8 * field_idx));
        if (field_idx >= (short_len ? fbd_pkg::LAST_IDX_SHORT : fbd_pkg::LAST_IDX_LONG)) begin
          field_idx = 2'd0;
          if (len_acc > fbd_pkg::MAX_FRAME_BYTES_DEF) begin
            halted = 1'b1;
            queue_result(8'd0, 32'd0, 1'b0, 1'b0, fbd_pkg::ST_LEN_ERROR);
          end else begin
            parse = fbd_pkg::PH_STAMP;
          end
        end else begin
          field_idx = field_idx + 2'd1;
        end
      end
      fbd_pkg::PH_STAMP: begin
        if (field_idx == 2'd0) stamp_acc = 32'd0;
        stamp_acc = stamp_acc | ({24'd0, b} << (8 * field_idx));
        if (field_idx != 2'd3) begin
          field_idx = field_idx + 2'd1;
        end else begin
          field_idx = 2'd0;
          key = len_acc[7:0] + stamp_acc[7:0] + fbd_pkg::KEY_BIAS;
          left = len_acc[16:0];
          if (left == 17'd0) begin
            queue_result(8'd0, stamp_acc, 1'b1, is_final(), fbd_pkg::ST_EMPTY);
            end_payload();
          end else begin
            parse = fbd_pkg::PH_PAYLOAD;
          end
        end
      end
      fbd_pkg::PH_PAYLOAD: begin
        queue_result(strip_key(b, key), stamp_acc, left == 17'd1,
                     (left == 17'd1) && is_final(), fbd_pkg::ST_PAYLOAD);
        fe = (left == 17'd1);
        key = key + fbd_pkg::KEY_STEP;
        left = left - 17'd1;
        if (fe) end_payload();
      end
      default: begin
        if (field_idx != 2'd3) begin
          field_idx = field_idx + 2'd1;
        end else begin
          field_idx = 2'd0;
          parse = fbd_pkg::PH_LENGTH;
          frames_done = frames_done + 31'd1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      divisor = 4'd0;
      short_len = 1'b0;
      chk_on = 1'b0;
      frame_total = 31'd1;
      parse = fbd_pkg::PH_LENGTH;
      field_idx = 2'd0;
      len_acc = 32'd0;
      stamp_acc = 32'd0;
      left = 17'd0;
      key = 8'd0;
      frames_done = 31'd0;
      halted = 1'b0;
      awaited.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.plain = plain_byte;
        seen.stamp = frame_time;
        seen.fend = frame_end;
        seen.rend = recording_end;
        seen.st = status;
        if (awaited.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: plain %02h time %08h end %0b rec %0b status %0d",
                     seen.plain, seen.stamp, seen.fend, seen.rend, seen.st);
        end else begin
          head = awaited.pop_front();
          if (head !== seen) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected plain %02h time %08h end %0b rec %0b status %0d",
                       head.plain, head.stamp, head.fend, head.rend, head.st);
              $display("          actual   plain %02h time %08h end %0b rec %0b status %0d",
                       seen.plain, seen.stamp, seen.fend, seen.rend, seen.st);
            end
          end
        end
      end
      if (in_valid && !in_stall) take_byte(body_byte);
      if (cfg_write) begin
        case (cfg_index)
          fbd_pkg::REG_TWIRL_DIVISOR: divisor = cfg_data[3:0];
          fbd_pkg::REG_SHORT_LENGTHS: short_len = cfg_data[0];
          fbd_pkg::REG_HAS_CHECKSUM:  chk_on = cfg_data[0];
          fbd_pkg::REG_FRAME_TOTAL:   frame_total = cfg_data[30:0];
          default: ;
        endcase
      end
    end
    pending <= awaited.size();
  end

endmodule

>>> tb/sv/frame_byte_deobfuscator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_byte_deobfuscator_core_tb
// Feeds recording bodies built from length, timestamp, payload and checksum
// fields: a short directed run over empty frames, recording end, settings
// changed inside a frame and byte extremes, then random frames under changing
// settings and flow control, and a final oversized length. Results are
// checked by the checker instance beside the block.
// ----------------------------------------------------------------------------
module frame_byte_deobfuscator_core_tb;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [fbd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fbd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     body_byte = 8'd0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     plain_byte;
  logic [31:0]                    frame_time;
  logic                           frame_end;
  logic                           recording_end;
  logic [1:0]                     status;
  int                             pending;
  int                             failures;

  int          send_pct = 0;
  int          stall_pct = 0;
  logic [3:0]  cur_div = 4'd0;
  logic        cur_short = 1'b0;
  logic        cur_chk = 1'b0;
  logic [30:0] cur_total = 31'd1;
  logic [3:0]  nxt_div = 4'd0;
  logic        nxt_short = 1'b0;
  logic        nxt_chk = 1'b0;
  int          cut_at = -1;
  int          byte_pos = 0;
  int          frames_sent = 0;
  int          items_sent = 0;

  frame_byte_deobfuscator_core i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .body_byte(body_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .plain_byte(plain_byte),
    .frame_time(frame_time),
    .frame_end(frame_end),
    .recording_end(recording_end),
    .status(status)
  );

  frame_byte_deobfuscator_checker i_checker (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .body_byte(body_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .plain_byte(plain_byte),
    .frame_time(frame_time),
    .frame_end(frame_end),
    .recording_end(recording_end),
    .status(status),
    .pending(pending),
    .failures(failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // hold off until every open result has come, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apply_config(input logic [3:0] dv, input logic sh, input logic ck,
                              input logic [30:0] tot);
    cfg_write <= 1'b1;
    cfg_index <= fbd_pkg::REG_TWIRL_DIVISOR;
    cfg_data <= {27'd0, dv};
    @(posedge clk);
    cfg_index <= fbd_pkg::REG_SHORT_LENGTHS;
    cfg_data <= {30'd0, sh};
    @(posedge clk);
    cfg_index <= fbd_pkg::REG_HAS_CHECKSUM;
    cfg_data <= {30'd0, ck};
    @(posedge clk);
    cfg_index <= fbd_pkg::REG_FRAME_TOTAL;
    cfg_data <= tot;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_div = dv;
    cur_short = sh;
    cur_chk = ck;
    cur_total = tot;
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (byte_pos == cut_at) begin
      settle();
      apply_config(nxt_div, nxt_short, nxt_chk, cur_total);
    end
    byte_pos++;
    while ((send_pct != 0) && ($urandom_range(99) < send_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    body_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame(input int len, input logic [31:0] stamp, input logic alt);
    logic [31:0] lw;
    int          i;
    logic        len_done;
    lw = len;
    byte_pos = 0;
    i = 0;
    len_done = 1'b0;
    while (!len_done) begin
      send_byte(lw[8*i +: 8]);
      len_done = (i >= (cur_short ? 1 : 3));
      i++;
    end
    for (i = 0; i < 4; i++) send_byte(stamp[8*i +: 8]);
    for (i = 0; i < len; i++) send_byte(alt ? {8{i[0]}} : 8'($urandom_range(255)));
    if (cur_chk) begin
      for (i = 0; i < 4; i++) send_byte(8'($urandom_range(255)));
    end
    frames_sent++;
    items_sent += byte_pos;
  endtask

  initial begin
    int          nf;
    int          len;
    int          r;
    int          f;
    logic [30:0] tot;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // odd divisor, then power of two and checksum switched on inside the payload
    apply_config(4'd15, 1'b1, 1'b0, 31'd1);
    nxt_div = 4'd8;
    nxt_short = 1'b1;
    nxt_chk = 1'b1;
    cut_at = 7;
    send_frame(2, 32'hFFFF_FFFF, 1'b1);
    cut_at = -1;
    send_byte(8'hA5);
    settle();
    apply_config(4'd8, 1'b1, 1'b1, 31'd3);
    // empty frame whose length field widens after its first byte
    nxt_div = 4'd0;
    nxt_short = 1'b0;
    nxt_chk = 1'b0;
    cut_at = 1;
    send_frame(0, $urandom, 1'b0);
    cut_at = -1;
    send_frame(1, 32'd0, 1'b0);
    send_byte(8'h5A);

    while (items_sent < 1050) begin
      settle();
      case ($urandom_range(3))
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 48; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 48; end
        default: begin send_pct = 31; stall_pct = 31; end
      endcase
      if ($urandom_range(7) == 0) begin
        tot = 31'h7FFF_FFFF;
        nf = $urandom_range(4, 1);
      end else begin
        nf = $urandom_range(5, 1);
        tot = 31'(frames_sent + nf);
      end
      apply_config(4'($urandom_range(15)), 1'($urandom_range(1)), 1'($urandom_range(1)), tot);
      for (f = 0; f < nf; f++) begin
        r = $urandom_range(99);
        if (r < 8) len = 0;
        else if (r < 90) len = $urandom_range(16, 1);
        else if (r < 98) len = $urandom_range(64, 17);
        else len = $urandom_range(400, 200);
        nxt_div = 4'($urandom_range(15));
        nxt_short = 1'($urandom_range(1));
        nxt_chk = 1'($urandom_range(1));
        if ($urandom_range(3) == 0) cut_at = $urandom_range(len + 11);
        else cut_at = -1;
        send_frame(len, $urandom, 1'b0);
      end
      cut_at = -1;
      if (frames_sent >= cur_total) begin
        repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
      end
    end

    // oversized length: the block stops for good, so this comes last
    settle();
    send_pct = 0;
    stall_pct = 0;
    apply_config(cur_div, 1'b0, cur_chk, 31'(frames_sent + 1));
    cut_at = -1;
    byte_pos = 0;
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h00);
    repeat (3) send_byte(8'($urandom_range(255)));
    settle();

    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
